@@ rtl/tknbl_pkg.sv @@
package tknbl_pkg;

    localparam int TIME_W = 32;
    localparam int ID_W = 16;
    localparam int SLOT_INDEX_W = 6;
    localparam int FUNC_W = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register map
    localparam logic [APB_ADDR_W-1:0] ADDR_TIME_LIMIT = 3'd0;
    localparam logic [TIME_W-1:0] TIME_LIMIT_RESET = 32'hFFFF_FFFF;

    // item function codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_OFFER = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    // controller to datapath commands
    typedef struct packed {
        logic offer;
        logic clear;
        logic rotate;
    } list_cmd_t;

endpackage

@@ rtl/tknbl_datapath.sv @@
module tknbl_datapath
    import tknbl_pkg::*;
#(
    parameter int LIST_DEPTH = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  list_cmd_t         cmd,
    input  logic [TIME_W-1:0] item_time,
    input  logic [ID_W-1:0]   item_id,
    input  logic [TIME_W-1:0] time_limit,
    output logic [TIME_W-1:0] head_time,
    output logic [ID_W-1:0]   head_id,
    output logic              head_valid
);

    logic [TIME_W-1:0] time_reg [LIST_DEPTH];
    logic [ID_W-1:0]   id_reg   [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] full_reg;

    logic [TIME_W-1:0] time_next [LIST_DEPTH];
    logic [ID_W-1:0]   id_next   [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] full_next;

    logic              below_limit;
    logic [LIST_DEPTH-1:0] take;
    logic [LIST_DEPTH-1:0] insert_here;

    // each cell decides whether the offered item belongs at or above it
    assign below_limit = item_time < time_limit;

    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            take[i] = below_limit && (!full_reg[i] || (item_time >= time_reg[i]));
        end
        insert_here[0] = take[0];
        for (int i = 1; i < LIST_DEPTH; i++)
        begin
            insert_here[i] = take[i] && !take[i-1];
        end
    end

    // cell update: insert, shift down, rotate towards the head, or clear
    always_comb
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            time_next[i] = time_reg[i];
            id_next[i]   = id_reg[i];
            full_next[i] = full_reg[i];
            if (cmd.clear)
            begin
                full_next[i] = 1'b0;
            end
            else if (cmd.rotate)
            begin
                time_next[i] = time_reg[(i + 1) % LIST_DEPTH];
                id_next[i]   = id_reg[(i + 1) % LIST_DEPTH];
                full_next[i] = full_reg[(i + 1) % LIST_DEPTH];
            end
            else if (cmd.offer)
            begin
                if (insert_here[i])
                begin
                    time_next[i] = item_time;
                    id_next[i]   = item_id;
                    full_next[i] = 1'b1;
                end
                else if (take[i])
                begin
                    time_next[i] = time_reg[(i + LIST_DEPTH - 1) % LIST_DEPTH];
                    id_next[i]   = id_reg[(i + LIST_DEPTH - 1) % LIST_DEPTH];
                    full_next[i] = full_reg[(i + LIST_DEPTH - 1) % LIST_DEPTH];
                end
            end
        end
    end

    // slot payload
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            time_reg[i] <= time_next[i];
            id_reg[i]   <= id_next[i];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= '0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    // head slot, empty slots read as zero
    assign head_valid = full_reg[0];
    assign head_time  = full_reg[0] ? time_reg[0] : '0;
    assign head_id    = full_reg[0] ? id_reg[0] : '0;

endmodule

@@ rtl/tknbl_ctrl.sv @@
module tknbl_ctrl
    import tknbl_pkg::*;
#(
    parameter int LIST_DEPTH = 10
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [FUNC_W-1:0]       func,
    output logic                    busy,
    output list_cmd_t               cmd,
    output logic                    result_valid,
    output logic                    last,
    output logic [SLOT_INDEX_W-1:0] slot_index
);

    localparam int CNT_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LIST_DEPTH - 1);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             accept;
    logic             at_last;

    assign accept  = start && (state_reg == ST_IDLE);
    assign at_last = (cnt_reg == CNT_LAST);

    // commands to the cell chain
    always_comb
    begin
        cmd = '0;
        if (accept)
        begin
            case (func)
                FUNC_OFFER: cmd.offer = 1'b1;
                FUNC_CLEAR: cmd.clear = 1'b1;
                default:    cmd = '0;
            endcase
        end
        cmd.rotate = (state_reg == ST_READ);
    end

    // state and slot counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (accept && (func == FUNC_READ))
                    begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (at_last)
                    begin
                        state_reg <= ST_IDLE;
                        cnt_reg   <= '0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    cnt_reg   <= '0;
                end
            endcase
        end
    end

    assign busy         = (state_reg == ST_READ);
    assign result_valid = (state_reg == ST_READ);
    assign last         = result_valid && at_last;
    assign slot_index   = SLOT_INDEX_W'(cnt_reg);

`ifndef NO_ASSERTIONS
    // a readout starts at the head slot
    a_read_starts_at_head: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> (slot_index == '0))
        else $error("readout did not start at slot zero");

    // results stream without gaps until the last slot
    a_read_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last) |=> (result_valid && (slot_index == $past(slot_index) + 1'b1)))
        else $error("readout stream broken");

    // after the last slot the block is free again
    a_free_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        last |=> !busy)
        else $error("still busy after last slot");

    // only one command reaches the chain at a time
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.offer, cmd.clear, cmd.rotate}))
        else $error("conflicting list commands");
`endif

endmodule

@@ rtl/top_k_newest_below_limit.sv @@
// offer and clear items are applied when accepted; a new item may start on the next cycle
// a readout item gives LIST_DEPTH results on consecutive cycles, the first in the
// cycle after the item is accepted; busy is high while the slots stream out
// throughput is one offer per cycle while not busy, set by the parallel compare-and-shift cells
// the receiver cannot stall; results appear for exactly one cycle each
// reset (rst_n, asynchronous) empties the list and sets time_limit to all ones
module top_k_newest_below_limit
    import tknbl_pkg::*;
#(
    parameter int LIST_DEPTH = 10
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // apb configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,
    // item port
    input  logic                    start,
    output logic                    busy,
    input  logic [FUNC_W-1:0]       func,
    input  logic [TIME_W-1:0]       item_time,
    input  logic [ID_W-1:0]         item_id,
    // result port
    output logic                    result_valid,
    output logic [SLOT_INDEX_W-1:0] slot_index,
    output logic [TIME_W-1:0]       slot_time,
    output logic [ID_W-1:0]         slot_id,
    output logic                    slot_valid,
    output logic                    last
);

    logic [TIME_W-1:0] time_limit_reg;
    logic              limit_sel;
    list_cmd_t         cmd;

    // register decode, word aligned
    assign limit_sel = (paddr[APB_ADDR_W-1:2] == ADDR_TIME_LIMIT[APB_ADDR_W-1:2]);
    assign pready    = 1'b1;
    assign prdata    = limit_sel ? time_limit_reg : '0;

    // time limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_limit_reg <= TIME_LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready && limit_sel)
        begin
            time_limit_reg <= pwdata[TIME_W-1:0];
        end
    end

    tknbl_ctrl #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .func         (func),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .last         (last),
        .slot_index   (slot_index)
    );

    tknbl_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .item_time  (item_time),
        .item_id    (item_id),
        .time_limit (time_limit_reg),
        .head_time  (slot_time),
        .head_id    (slot_id),
        .head_valid (slot_valid)
    );

endmodule
